// ===== rtl/esd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, codes and helpers for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int COUNT_BITS = 16;

    typedef enum logic [3:0] {
        PH_NORMAL = 4'd0,
        PH_ESC    = 4'd1,
        PH_HEX    = 4'd2,
        PH_UNI    = 4'd3,
        PH_ZERO   = 4'd4,
        PH_OCT    = 4'd5
    } phase_t;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_END  = 2'd1,
        K_ERR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        E_NONE      = 3'd0,
        E_UNKNOWN   = 3'd1,
        E_BAD_HEX   = 3'd2,
        E_OCT_89    = 3'd3,
        E_OCT_SHORT = 3'd4,
        E_OCT_BIG   = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       start_req;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_out;
        err_t        error_code;
        logic [15:0] consumed;
        logic        last;
    } result_t;

    // up to three results from one request
    typedef struct packed {
        logic [1:0]       count;
        result_t [2:0]    items;
    } res_bundle_t;

    function automatic result_t make_result(kind_t k, logic [7:0] b, err_t e,
                                            logic [15:0] cons);
        result_t r;
        r.kind       = k;
        r.byte_out   = b;
        r.error_code = e;
        r.consumed   = cons;
        r.last       = 1'b0;
        return r;
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= "0" && c <= "9") v = {1'b0, c[3:0]};
        else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

endpackage

// ===== rtl/esd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_if
// Valid/ready channels for character requests and decoded results.
// ----------------------------------------------------------------------------
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       start_req;
    logic       end_of_text;

    modport source (output valid, output char_in, output start_req,
                    output end_of_text, input ready);
    modport sink   (input valid, input char_in, input start_req,
                    input end_of_text, output ready);
endinterface

interface esd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [2:0]  error_code;
    logic [15:0] consumed;
    logic        last;

    modport source (output valid, output kind, output byte_out, output error_code,
                    output consumed, output last, input ready);
    modport sink   (input valid, input kind, input byte_out, input error_code,
                    input consumed, input last, output ready);
endinterface

// ===== rtl/escape_sequence_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// C string escape decoder, one character request per cycle while the result channel can take its results.
// ----------------------------------------------------------------------------
// Takes one character request per clock and decodes it in a single pass
// between an input register and a result register; a request waits in the
// input register until the result register can load, then enters it, and
// its first result is offered from then on. Requests that give zero or one
// result sustain one request per cycle. A request that gives two or three
// results (escaped zero followed by text, \u escapes, a byte followed by
// the end of the field) holds the input while the result register drains
// one result per cycle. Stalls on the result channel hold the input for as
// long as they last. After reset the decoder is halted until a request with
// start_req set.
module escape_sequence_decoder (
    input  logic     clk,
    input  logic     rst_n,
    esd_in_if.sink   char_req,
    esd_out_if.source result
);
    import esd_pkg::*;

    logic        item_valid;
    in_item_t    item;
    logic        can_load;
    logic        take;
    res_bundle_t bundle;

    assign take = item_valid && can_load;

    esd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (char_req),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    esd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .bundle (bundle)
    );

    esd_result_buf u_result_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .bundle   (bundle),
        .can_load (can_load),
        .out_ch   (result)
    );
endmodule

// ===== rtl/esd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_in_stage
// Input register: holds one character request until the decoder takes it.
// ----------------------------------------------------------------------------
module esd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    esd_in_if.sink            in_ch,
    input  logic              take,
    output logic              item_valid,
    output esd_pkg::in_item_t item
);
    import esd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign in_ch.ready = !valid_reg || take;
    assign accept      = in_ch.valid && in_ch.ready;
    assign valid_next  = accept ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.char_in     <= in_ch.char_in;
            item_reg.start_req   <= in_ch.start_req;
            item_reg.end_of_text <= in_ch.end_of_text;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// ===== rtl/esd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_core
// Decoder state and the single-pass decode of one character into results.
// ----------------------------------------------------------------------------
module esd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  esd_pkg::in_item_t    item,
    output esd_pkg::res_bundle_t bundle
);
    import esd_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [15:0]           gval_reg, gval_next;
    logic [2:0]            digits_reg, digits_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  halted_reg, halted_next;

    always_comb
    begin
        phase_t                ph;
        logic [15:0]           gv;
        logic [2:0]            ds;
        logic [COUNT_BITS-1:0] cnt;
        logic                  hlt;
        logic                  ends;
        logic [1:0]            n;
        result_t [2:0]         res;
        logic [4:0]            hv;
        logic [7:0]            c;
        logic                  do_plain;
        logic                  do_oct;
        logic [31:0]           cnt32;

        c        = item.char_in;
        ph       = phase_reg;
        gv       = gval_reg;
        ds       = digits_reg;
        cnt      = count_reg;
        hlt      = halted_reg;
        ends     = 1'b0;
        n        = 2'd0;
        res      = '0;
        hv       = hex_val(c);
        do_plain = 1'b0;
        do_oct   = 1'b0;
        cnt32    = '0;

        if (item.start_req)
        begin
            ph  = PH_NORMAL;
            gv  = '0;
            ds  = '0;
            cnt = '0;
            hlt = 1'b0;
        end

        if (!hlt)
        begin
            unique case (ph)
                PH_ESC:
                begin
                    ph = PH_NORMAL;
                    case (c)
                        "a": begin res[n] = make_result(K_BYTE, 8'd7, E_NONE, '0);  n = n + 2'd1; end
                        "b": begin res[n] = make_result(K_BYTE, 8'd8, E_NONE, '0);  n = n + 2'd1; end
                        "f": begin res[n] = make_result(K_BYTE, 8'd12, E_NONE, '0); n = n + 2'd1; end
                        "n": begin res[n] = make_result(K_BYTE, 8'd10, E_NONE, '0); n = n + 2'd1; end
                        "r": begin res[n] = make_result(K_BYTE, 8'd13, E_NONE, '0); n = n + 2'd1; end
                        "t": begin res[n] = make_result(K_BYTE, 8'd9, E_NONE, '0);  n = n + 2'd1; end
                        "v": begin res[n] = make_result(K_BYTE, 8'd11, E_NONE, '0); n = n + 2'd1; end
                        "\\", "'", "\"", "?":
                        begin
                            res[n] = make_result(K_BYTE, c, E_NONE, '0);
                            n = n + 2'd1;
                        end
                        8'h0A, 8'h0D: ;
                        "x":
                        begin
                            ph = PH_HEX;
                            gv = '0;
                            ds = '0;
                        end
                        "u", "U":
                        begin
                            ph = PH_UNI;
                            gv = '0;
                            ds = '0;
                        end
                        "0": ph = PH_ZERO;
                        "8", "9":
                        begin
                            res[n] = make_result(K_ERR, 8'd0, E_OCT_89, '0);
                            n = n + 2'd1;
                            hlt = 1'b1;
                        end
                        "1", "2", "3", "4", "5", "6", "7":
                        begin
                            ph = PH_OCT;
                            gv = {13'd0, c[2:0]};
                            ds = 3'd1;
                        end
                        default:
                        begin
                            res[n] = make_result(K_ERR, 8'd0, E_UNKNOWN, '0);
                            n = n + 2'd1;
                            hlt = 1'b1;
                        end
                    endcase
                end
                PH_HEX, PH_UNI:
                begin
                    if (hv[4])
                    begin
                        res[n] = make_result(K_ERR, 8'd0, E_BAD_HEX, '0);
                        n = n + 2'd1;
                        hlt = 1'b1;
                        ph = PH_NORMAL;
                    end
                    else
                    begin
                        gv = {gv[11:0], hv[3:0]};
                        ds = ds + 3'd1;
                        if ((ph == PH_HEX && ds >= 3'd2) || (ph == PH_UNI && ds >= 3'd4))
                        begin
                            if (ph == PH_UNI)
                            begin
                                res[n] = make_result(K_BYTE, gv[15:8], E_NONE, '0);
                                n = n + 2'd1;
                            end
                            res[n] = make_result(K_BYTE, gv[7:0], E_NONE, '0);
                            n = n + 2'd1;
                            ph = PH_NORMAL;
                        end
                    end
                end
                PH_ZERO:
                begin
                    if (is_digit(c))
                    begin
                        ph     = PH_OCT;
                        gv     = '0;
                        ds     = 3'd1;
                        do_oct = 1'b1;
                    end
                    else
                    begin
                        ph = PH_NORMAL;
                        res[n] = make_result(K_BYTE, 8'd0, E_NONE, '0);
                        n = n + 2'd1;
                        do_plain = 1'b1;
                    end
                end
                PH_OCT:    do_oct   = 1'b1;
                PH_NORMAL: do_plain = 1'b1;
                default:   do_plain = 1'b1;
            endcase

            if (do_oct)
            begin
                if (c == "8" || c == "9")
                begin
                    res[n] = make_result(K_ERR, 8'd0, E_OCT_89, '0);
                    n = n + 2'd1;
                    hlt = 1'b1;
                    ph = PH_NORMAL;
                end
                else if (!is_digit(c))
                begin
                    res[n] = make_result(K_ERR, 8'd0, E_OCT_SHORT, '0);
                    n = n + 2'd1;
                    hlt = 1'b1;
                    ph = PH_NORMAL;
                end
                else
                begin
                    gv = {gv[12:0], c[2:0]};
                    ds = ds + 3'd1;
                    if (ds >= 3'd3)
                    begin
                        ph = PH_NORMAL;
                        if (gv >= 16'd256)
                        begin
                            res[n] = make_result(K_ERR, 8'd0, E_OCT_BIG, '0);
                            n = n + 2'd1;
                            hlt = 1'b1;
                        end
                        else
                        begin
                            res[n] = make_result(K_BYTE, gv[7:0], E_NONE, '0);
                            n = n + 2'd1;
                        end
                    end
                end
            end

            if (do_plain)
            begin
                if (c == "\\")
                begin
                    ph = PH_ESC;
                end
                else if (c == 8'h0A)
                begin
                    ends = 1'b1;
                end
                else
                begin
                    res[n] = make_result(K_BYTE, c, E_NONE, '0);
                    n = n + 2'd1;
                end
            end

            if (!hlt)
            begin
                if (!ends && cnt != '1)
                begin
                    cnt = cnt + {{(COUNT_BITS-1){1'b0}}, 1'b1};
                end
                if (!ends && item.end_of_text && ph != PH_NORMAL)
                begin
                    if (ph == PH_HEX || ph == PH_UNI)
                        res[n] = make_result(K_ERR, 8'd0, E_BAD_HEX, '0);
                    else if (ph == PH_ESC)
                        res[n] = make_result(K_ERR, 8'd0, E_UNKNOWN, '0);
                    else
                        res[n] = make_result(K_ERR, 8'd0, E_OCT_SHORT, '0);
                    n = n + 2'd1;
                    hlt = 1'b1;
                    ph = PH_NORMAL;
                end
                else if (ends || item.end_of_text)
                begin
                    cnt32 = 32'(cnt);
                    res[n] = make_result(K_END, 8'd0, E_NONE,
                                         (cnt32 > 32'h0000_FFFF) ? 16'hFFFF : cnt32[15:0]);
                    n = n + 2'd1;
                    hlt = 1'b1;
                    ph = PH_NORMAL;
                end
            end

            if (n != 2'd0)
            begin
                res[n - 2'd1].last = 1'b1;
            end
        end

        phase_next   = ph;
        gval_next    = gv;
        digits_next  = ds;
        count_next   = cnt;
        halted_next  = hlt;
        bundle.count = n;
        bundle.items = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_NORMAL;
            gval_reg   <= '0;
            digits_reg <= '0;
            count_reg  <= '0;
            halted_reg <= 1'b1;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            gval_reg   <= gval_next;
            digits_reg <= digits_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
        end
    end
endmodule

// ===== rtl/esd_result_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_result_buf
// Result register: holds the results of one request and drains them in order.
// ----------------------------------------------------------------------------
module esd_result_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  esd_pkg::res_bundle_t bundle,
    output logic                 can_load,
    esd_out_if.source            out_ch
);
    import esd_pkg::*;

    result_t [2:0] items_reg, items_next;
    logic [1:0]    count_reg, count_next;
    logic          pop;

    assign out_ch.valid      = (count_reg != 2'd0);
    assign pop               = out_ch.valid && out_ch.ready;
    assign can_load          = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ch.ready);
    assign out_ch.kind       = items_reg[0].kind;
    assign out_ch.byte_out   = items_reg[0].byte_out;
    assign out_ch.error_code = items_reg[0].error_code;
    assign out_ch.consumed   = items_reg[0].consumed;
    assign out_ch.last       = items_reg[0].last;

    always_comb
    begin
        items_next = items_reg;
        count_next = count_reg;
        if (load)
        begin
            items_next = bundle.items;
            count_next = bundle.count;
        end
        else if (pop)
        begin
            items_next = {items_reg[2], items_reg[2:1]};
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end
endmodule
